FILE: hw/rtl/tiuv_pkg.sv
// Package for the tagged identifier UTF-8 validator.
// Holds the beat and result types, character codes and the table of banned codepoint ranges.
// Depends on nothing; the top level, the parser and the classifier use it.
`timescale 1ns / 1ps

package tiuv_pkg;

  localparam int CpWidth = 21;
  typedef logic [CpWidth-1:0] cp_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic matched;
  } result_t;

  localparam logic [7:0] ChD          = 8'h64;
  localparam logic [7:0] ChI          = 8'h69;
  localparam logic [7:0] ChN          = 8'h6E;
  localparam logic [7:0] ChColon      = 8'h3A;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChOne        = 8'h31;
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLowA       = 8'h61;
  localparam logic [7:0] ChLowZ       = 8'h7A;
  localparam logic [7:0] ChUpA        = 8'h41;
  localparam logic [7:0] ChUpZ        = 8'h5A;

  localparam int NumRanges = 30;

  localparam cp_t RangeLo [NumRanges] = '{
    21'h00000, 21'h0007F, 21'h000AD, 21'h00600, 21'h0061C, 21'h006DD,
    21'h0070F, 21'h008E2, 21'h0180E, 21'h0200B, 21'h0202A, 21'h02060,
    21'h02066, 21'h0FEFF, 21'h0FFF9, 21'h110BD, 21'h110CD, 21'h13430,
    21'h1BCA0, 21'h1D173, 21'hE0001, 21'hE0020, 21'h00020, 21'h000A0,
    21'h01680, 21'h02000, 21'h02028, 21'h0202F, 21'h0205F, 21'h03000
  };

  localparam cp_t RangeHi [NumRanges] = '{
    21'h0001F, 21'h0009F, 21'h000AD, 21'h00605, 21'h0061C, 21'h006DD,
    21'h0070F, 21'h008E2, 21'h0180E, 21'h0200F, 21'h0202E, 21'h02064,
    21'h0206F, 21'h0FEFF, 21'h0FFFB, 21'h110BD, 21'h110CD, 21'h13438,
    21'h1BCA3, 21'h1D17A, 21'hE0001, 21'hE007F, 21'h00020, 21'h000A0,
    21'h01680, 21'h0200A, 21'h02029, 21'h0202F, 21'h0205F, 21'h03000
  };

endpackage

FILE: hw/rtl/tiuv_if.sv
// Stream interfaces for the validator: byte beats in, match results out.
// Uses nothing from tiuv_pkg.
`timescale 1ns / 1ps

interface tiuv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tiuv_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

FILE: hw/rtl/tagged_identifier_utf8_validator_top.sv
// Top level of the tagged identifier UTF-8 validator.
// Depends on tiuv_pkg, tiuv_if and tiuv_parser.
//
// The block checks a string of UTF-8 bytes against d:_(i:[1-9][0-9]*|n:[a-zA-Z0-9-]+)_
// followed by one or more codepoints that are not control, format or separator
// characters. Bytes enter one per beat on in_i, the last byte of a string
// flagged by last_byte. Each string yields exactly one beat on out_o, with
// matched high when the whole string fits; other bytes yield nothing.
// A byte is taken every cycle unless a stalled last byte waits in the input register.
// A beat accepted on in_i is held in an input register and processed from there; the
// result of its string is registered in an output register that drives out_o.
// The parse state advances once per byte.
// When out_o is stalled, a finished result stays in the output register and
// the bytes of the next string still flow through; its last byte then waits
// in the input register until the output register frees, and in_i stalls
// behind it.
// Reset clears the parse state and empties both registers; the first byte
// after reset starts a new string.
`timescale 1ns / 1ps

module tagged_identifier_utf8_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tiuv_in_if.sink    in_i,
  tiuv_out_if.source out_o
);

  logic              in_vld_q;
  tiuv_pkg::beat_t   in_beat_q;
  logic              out_vld_q;
  logic              out_matched_q;
  logic              s1_fire;
  tiuv_pkg::result_t result;

  assign s1_fire  = in_vld_q && (!in_beat_q.last_byte || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_beat_q.data_byte <= in_i.data_byte;
      in_beat_q.last_byte <= in_i.last_byte;
    end
  end

  tiuv_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .beat_i   (in_beat_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire && in_beat_q.last_byte) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && in_beat_q.last_byte) begin
      out_matched_q <= result.matched;
    end
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.matched = out_matched_q;

endmodule

FILE: hw/rtl/tiuv_classify.sv
// Codepoint classifier: flags control, format and separator codepoints.
// Depends on tiuv_pkg for the banned range table.
`timescale 1ns / 1ps

module tiuv_classify (
  input  tiuv_pkg::cp_t cp_i,
  output logic          banned_o
);

  logic [tiuv_pkg::NumRanges-1:0] hit;

  always_comb begin
    for (int k = 0; k < tiuv_pkg::NumRanges; k++) begin
      hit[k] = (cp_i >= tiuv_pkg::RangeLo[k]) && (cp_i <= tiuv_pkg::RangeHi[k]);
    end
  end

  assign banned_o = |hit;

endmodule

FILE: hw/rtl/tiuv_parser.sv
// Parse state of the validator: prefix recognizer, UTF-8 decoder and reject flag.
// Depends on tiuv_pkg and instantiates tiuv_classify.
`timescale 1ns / 1ps

module tiuv_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tiuv_pkg::beat_t   beat_i,
  output tiuv_pkg::result_t result_o
);

  localparam logic [3:0] PhD      = 4'd0;
  localparam logic [3:0] PhColon0 = 4'd1;
  localparam logic [3:0] PhUs0    = 4'd2;
  localparam logic [3:0] PhKind   = 4'd3;
  localparam logic [3:0] PhIColon = 4'd4;
  localparam logic [3:0] PhIFirst = 4'd5;
  localparam logic [3:0] PhIDigit = 4'd6;
  localparam logic [3:0] PhNColon = 4'd7;
  localparam logic [3:0] PhNFirst = 4'd8;
  localparam logic [3:0] PhNChar  = 4'd9;
  localparam logic [3:0] PhTail0  = 4'd10;
  localparam logic [3:0] PhTail1  = 4'd11;

  logic [3:0]    phase_q, phase_d;
  logic          rej_q, rej_d, rej_pre;
  logic [1:0]    cont_q, cont_d;
  tiuv_pkg::cp_t acc_q, acc_d;
  logic          check;
  logic          banned;
  logic [7:0]    b;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= tiuv_pkg::ChZero) && (c <= tiuv_pkg::ChNine);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= tiuv_pkg::ChLowA) && (c <= tiuv_pkg::ChLowZ)) ||
           ((c >= tiuv_pkg::ChUpA) && (c <= tiuv_pkg::ChUpZ)) ||
           is_digit(c) || (c == tiuv_pkg::ChDash);
  endfunction

  assign b = beat_i.data_byte;

  always_comb begin
    phase_d = phase_q;
    rej_pre = rej_q;
    cont_d  = cont_q;
    acc_d   = acc_q;
    check   = 1'b0;
    if (!rej_q) begin
      unique case (phase_q)
        PhD: begin
          if (b == tiuv_pkg::ChD) phase_d = PhColon0; else rej_pre = 1'b1;
        end
        PhColon0: begin
          if (b == tiuv_pkg::ChColon) phase_d = PhUs0; else rej_pre = 1'b1;
        end
        PhUs0: begin
          if (b == tiuv_pkg::ChUnderscore) phase_d = PhKind; else rej_pre = 1'b1;
        end
        PhKind: begin
          if (b == tiuv_pkg::ChI) phase_d = PhIColon;
          else if (b == tiuv_pkg::ChN) phase_d = PhNColon;
          else rej_pre = 1'b1;
        end
        PhIColon: begin
          if (b == tiuv_pkg::ChColon) phase_d = PhIFirst; else rej_pre = 1'b1;
        end
        PhIFirst: begin
          if ((b >= tiuv_pkg::ChOne) && (b <= tiuv_pkg::ChNine)) phase_d = PhIDigit;
          else rej_pre = 1'b1;
        end
        PhIDigit: begin
          if (is_digit(b)) phase_d = PhIDigit;
          else if (b == tiuv_pkg::ChUnderscore) phase_d = PhTail0;
          else rej_pre = 1'b1;
        end
        PhNColon: begin
          if (b == tiuv_pkg::ChColon) phase_d = PhNFirst; else rej_pre = 1'b1;
        end
        PhNFirst: begin
          if (is_name_char(b)) phase_d = PhNChar; else rej_pre = 1'b1;
        end
        PhNChar: begin
          if (is_name_char(b)) phase_d = PhNChar;
          else if (b == tiuv_pkg::ChUnderscore) phase_d = PhTail0;
          else rej_pre = 1'b1;
        end
        PhTail0, PhTail1: begin
          if (cont_q != 2'd0) begin
            acc_d  = {acc_q[tiuv_pkg::CpWidth-7:0], b[5:0]};
            cont_d = cont_q - 2'd1;
            check  = (cont_q == 2'd1);
          end else begin
            phase_d = PhTail1;
            casez (b)
              8'b0???????: begin
                acc_d = {13'd0, b};
                check = 1'b1;
              end
              8'b110?????: begin
                acc_d  = {16'd0, b[4:0]};
                cont_d = 2'd1;
              end
              8'b1110????: begin
                acc_d  = {17'd0, b[3:0]};
                cont_d = 2'd2;
              end
              8'b11110???: begin
                acc_d  = {18'd0, b[2:0]};
                cont_d = 2'd3;
              end
              default: begin
                acc_d = '0;
                check = 1'b1;
              end
            endcase
          end
        end
        default: rej_pre = 1'b1;
      endcase
    end
  end

  tiuv_classify u_classify (
    .cp_i     (acc_d),
    .banned_o (banned)
  );

  assign rej_d = rej_pre | (check & banned);

  assign result_o.matched = !rej_d && (phase_d == PhTail1) && (cont_d == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhD;
      rej_q   <= 1'b0;
      cont_q  <= 2'd0;
      acc_q   <= '0;
    end else if (fire_i) begin
      if (beat_i.last_byte) begin
        phase_q <= PhD;
        rej_q   <= 1'b0;
        cont_q  <= 2'd0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        rej_q   <= rej_d;
        cont_q  <= cont_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

FILE: hw/rtl/tiuv_checker.sv
// Port-level checks for the validator top level, attached by bind.
// Depends on tagged_identifier_utf8_validator_top and its interfaces.
`timescale 1ns / 1ps

module tiuv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_matched_i
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result beat dropped while stalled.");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_matched_i))
    else $error("Stalled result changed.");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Input stalled with an empty output register.");

  a_result_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("Result appeared without a last byte two cycles earlier.");

endmodule

bind tagged_identifier_utf8_validator_top tiuv_checker u_tiuv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last_byte),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched)
);
